// ===== rtl/das_pkg.sv =====
package das_pkg;

    localparam int DIM_W    = 7;
    localparam int DIM_MAX  = 64;
    localparam int POS_W    = 6;
    localparam int PAGE_W   = 10;
    localparam int HANDLE_W = 10;
    localparam int LIVE_W   = 11;
    localparam int CAP_W    = 13;
    localparam int STATUS_W = 2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd2;

    localparam logic CFG_COLS = 1'b0;
    localparam logic CFG_ROWS = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_CHECK,
        ST_PLACE_A,
        ST_PLACE_F,
        ST_PLACE_L,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        PL_IDLE,
        PL_PAGE,
        PL_LINE
    } place_state_t;

    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic [POS_W-1:0]  col;
        logic [POS_W-1:0]  row;
        logic              at_start;
    } place_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PAGE_W-1:0]   page_index;
        logic [POS_W-1:0]    slot_col;
        logic [POS_W-1:0]    slot_row;
        logic                new_page;
        logic                page_released;
        logic                moved;
        logic [HANDLE_W-1:0] moved_handle;
        logic [PAGE_W-1:0]   from_page;
        logic [POS_W-1:0]    from_col;
        logic [POS_W-1:0]    from_row;
        logic [LIVE_W-1:0]   live_count;
    } result_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > DIM_W'(DIM_MAX))
            r = DIM_W'(DIM_MAX);
        else
            r = v;
        return r;
    endfunction

endpackage

// ===== rtl/das_divider.sv =====
module das_divider
    import das_pkg::*;
#(
    parameter int NW = 10
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NW-1:0]    num,
    input  logic [CAP_W-1:0] den,
    output logic             done,
    output logic [NW-1:0]    quot,
    output logic [CAP_W-1:0] rem
);

    localparam int CW = $clog2(NW + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [NW-1:0]    quot_reg;
    logic [CAP_W-1:0] rem_reg;
    logic [CAP_W-1:0] den_reg;

    logic [CAP_W:0]   trial;
    logic [CAP_W:0]   diff;
    logic             fits;

    // restoring division, one quotient bit per cycle
    assign trial = {rem_reg, quot_reg[NW-1]};
    assign fits  = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= num;
            rem_reg  <= '0;
            den_reg  <= den;
        end
        else if (busy_reg)
        begin
            quot_reg <= (quot_reg << 1) | NW'(fits);
            rem_reg  <= fits ? diff[CAP_W-1:0] : trial[CAP_W-1:0];
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

// ===== rtl/das_place.sv =====
module das_place
    import das_pkg::*;
#(
    parameter int SW = 10
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SW-1:0]    slot,
    input  logic [DIM_W-1:0] cols,
    input  logic [CAP_W-1:0] cap,
    output logic             done,
    output place_t           res
);

    place_state_t      state_reg, state_next;
    logic              done_reg;
    place_t            res_reg;
    logic [DIM_W-1:0]  cols_reg;
    logic [PAGE_W-1:0] page_reg;
    logic [CAP_W-1:0]  on_reg;

    logic              div_start;
    logic [SW-1:0]     div_num;
    logic [CAP_W-1:0]  div_den;
    logic              div_done;
    logic [SW-1:0]     div_quot;
    logic [CAP_W-1:0]  div_rem;

    das_divider #(.NW(SW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot),
        .rem   (div_rem)
    );

    // first pass: slot / cap -> page, offset; second: offset / cols -> row, col
    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        div_num    = slot;
        div_den    = cap;
        case (state_reg)
            PL_IDLE:
            begin
                if (start)
                begin
                    div_start  = 1'b1;
                    state_next = PL_PAGE;
                end
            end
            PL_PAGE:
            begin
                div_num = SW'(div_rem);
                div_den = CAP_W'(cols_reg);
                if (div_done)
                begin
                    div_start  = 1'b1;
                    state_next = PL_LINE;
                end
            end
            PL_LINE:
            begin
                if (div_done)
                    state_next = PL_IDLE;
            end
            default:
            begin
                state_next = PL_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PL_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == PL_LINE) && div_done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == PL_IDLE && start)
            cols_reg <= cols;
        if (state_reg == PL_PAGE && div_done)
        begin
            page_reg <= PAGE_W'(div_quot);
            on_reg   <= div_rem;
        end
        if (state_reg == PL_LINE && div_done)
        begin
            res_reg.page     <= page_reg;
            res_reg.col      <= POS_W'(div_rem);
            res_reg.row      <= POS_W'(div_quot);
            res_reg.at_start <= (on_reg == '0);
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

// ===== rtl/dense_atlas_slot_allocator.sv =====
// Channel | Dir | Signals                     | Payload
// s_      | in  | s_tvalid s_tready s_tdata   | tdata: handle; tuser: command
// m_      | out | m_tvalid m_tready m_tdata   | tdata: placement fields; tuser: status
// cfg_    | in  | cfg_we cfg_index cfg_data   | 0 cols_per_page, 1 rows_per_page
//
// One item at a time; s_tready is high only when the sequencer is idle.
// With the output free, an allocate runs one placement and a free two; each placement
// makes two passes through the shared divider (SW = log2 MAX_SLOTS quotient bits, one
// quotient bit per cycle). Errors skip placement and finish straight from the check.
// Slot tables need no clearing after reset. A finished result moves to the output register
// once that is free; while it waits there, the next item is taken.
module dense_atlas_slot_allocator
    import das_pkg::*;
#(
    parameter int MAX_SLOTS   = 1024,
    parameter int MAX_HANDLES = 1024
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [15:0]      s_tdata,   // [9:0] handle
    input  logic [0:0]       s_tuser,   // [0] command
    output logic             m_tvalid,
    input  logic             m_tready,
    // [9:0] page_index, [15:10] slot_col, [21:16] slot_row, [22] new_page,
    // [23] page_released, [24] moved, [34:25] moved_handle, [44:35] from_page,
    // [50:45] from_col, [56:51] from_row, [67:57] live_count
    output logic [71:0]      m_tdata,
    output logic [1:0]       m_tuser,   // [1:0] status
    input  logic             cfg_we,
    input  logic [0:0]       cfg_index,
    input  logic [DIM_W-1:0] cfg_data
);

    localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int HW = (MAX_HANDLES > 1) ? $clog2(MAX_HANDLES) : 1;
    localparam int LW = $clog2(MAX_SLOTS + 1);

    logic [HW-1:0] slot_owner [MAX_SLOTS];
    logic [SW-1:0] handle_slot [MAX_HANDLES];

    state_t            state_reg, state_next;
    logic [DIM_W-1:0]  cols_reg, rows_reg;
    logic [LW-1:0]     live_reg, live_next;
    logic              cmd_reg;
    logic [HANDLE_W-1:0] h_reg;
    logic [SW-1:0]     hs_rd_reg;
    logic [HW-1:0]     owner_rd_reg;
    logic              hs_lt_reg;
    result_t           res_reg, res_next;
    result_t           m_res_reg;
    result_t           m_load_res;
    logic              m_valid_reg, m_valid_next;
    logic              m_load;

    logic [DIM_W-1:0]  cols_c;
    logic [CAP_W-1:0]  cap;
    logic              in_fire;
    logic [HW-1:0]     hidx;
    logic [HW-1:0]     in_hidx;
    logic [SW-1:0]     last;
    logic              h_ok;
    logic              h_live;

    logic              owner_re;
    logic [SW-1:0]     owner_raddr;
    logic              owner_we;
    logic [SW-1:0]     owner_waddr;
    logic [HW-1:0]     owner_wdata;
    logic              hs_we;
    logic [HW-1:0]     hs_waddr;
    logic [SW-1:0]     hs_wdata;

    logic              place_start;
    logic [SW-1:0]     place_slot;
    logic              place_done;
    place_t            place_res;

    assign cols_c  = clamp_dim(cols_reg);
    assign cap     = CAP_W'(cols_c) * CAP_W'(clamp_dim(rows_reg));
    assign in_fire = s_tvalid && s_tready;
    assign in_hidx = HW'(s_tdata[HANDLE_W-1:0]);
    assign hidx    = HW'(h_reg);
    assign last    = SW'(live_reg - LW'(1));
    assign h_ok    = 32'(h_reg) < 32'(MAX_HANDLES);
    assign s_tready = (state_reg == ST_IDLE);

    // a handle is live when its slot lies below the count and that slot points back
    always_comb
    begin
        if (hs_lt_reg && (owner_rd_reg == hidx))
            h_live = 1'b1;
        else
            h_live = 1'b0;
    end

    das_place #(.SW(SW)) u_place (
        .clk   (clk),
        .rst_n (rst_n),
        .start (place_start),
        .slot  (place_slot),
        .cols  (cols_c),
        .cap   (cap),
        .done  (place_done),
        .res   (place_res)
    );

    always_comb
    begin
        state_next   = state_reg;
        live_next    = live_reg;
        res_next     = res_reg;
        owner_re     = 1'b0;
        owner_raddr  = hs_rd_reg;
        owner_we     = 1'b0;
        owner_waddr  = SW'(live_reg);
        owner_wdata  = hidx;
        hs_we        = 1'b0;
        hs_waddr     = hidx;
        hs_wdata     = SW'(live_reg);
        place_start  = 1'b0;
        place_slot   = SW'(live_reg);
        m_load       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    res_next   = '0;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                owner_re   = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (cmd_reg == CMD_ALLOC)
                begin
                    if (live_reg >= LW'(MAX_SLOTS))
                    begin
                        res_next.status = STATUS_FULL;
                        state_next      = ST_DONE;
                    end
                    else if (!h_ok || h_live)
                    begin
                        res_next.status = STATUS_BAD;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        place_start = 1'b1;
                        state_next  = ST_PLACE_A;
                    end
                end
                else
                begin
                    if (live_reg == '0 || !h_ok || !h_live)
                    begin
                        res_next.status = STATUS_BAD;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        owner_re    = 1'b1;
                        owner_raddr = last;
                        place_start = 1'b1;
                        place_slot  = hs_rd_reg;
                        state_next  = ST_PLACE_F;
                    end
                end
            end
            ST_PLACE_A:
            begin
                if (place_done)
                begin
                    res_next.page_index = place_res.page;
                    res_next.slot_col   = place_res.col;
                    res_next.slot_row   = place_res.row;
                    res_next.new_page   = place_res.at_start;
                    owner_we   = 1'b1;
                    hs_we      = 1'b1;
                    live_next  = live_reg + LW'(1);
                    state_next = ST_DONE;
                end
            end
            ST_PLACE_F:
            begin
                if (place_done)
                begin
                    res_next.page_index = place_res.page;
                    res_next.slot_col   = place_res.col;
                    res_next.slot_row   = place_res.row;
                    place_start = 1'b1;
                    place_slot  = last;
                    state_next  = ST_PLACE_L;
                end
            end
            ST_PLACE_L:
            begin
                if (place_done)
                begin
                    res_next.page_released = place_res.at_start;
                    if (hs_rd_reg != last)
                    begin
                        // tail tile drops into the freed slot
                        res_next.moved        = 1'b1;
                        res_next.moved_handle = HANDLE_W'(owner_rd_reg);
                        res_next.from_page    = place_res.page;
                        res_next.from_col     = place_res.col;
                        res_next.from_row     = place_res.row;
                        owner_we    = 1'b1;
                        owner_waddr = hs_rd_reg;
                        owner_wdata = owner_rd_reg;
                        hs_we       = 1'b1;
                        hs_waddr    = owner_rd_reg;
                        hs_wdata    = hs_rd_reg;
                    end
                    live_next  = LW'(last);
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_load     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (m_load)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;
        else
            m_valid_next = m_valid_reg;
    end

    always_comb
    begin
        m_load_res            = res_reg;
        m_load_res.live_count = LIVE_W'(live_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            live_reg    <= '0;
            m_valid_reg <= 1'b0;
            cols_reg    <= DIM_W'(8);
            rows_reg    <= DIM_W'(8);
        end
        else
        begin
            state_reg   <= state_next;
            live_reg    <= live_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_COLS: cols_reg <= cfg_data;
                    CFG_ROWS: rows_reg <= cfg_data;
                    default:  cols_reg <= cols_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (in_fire)
        begin
            cmd_reg <= s_tuser[0];
            h_reg   <= s_tdata[HANDLE_W-1:0];
        end
        if (state_reg == ST_LOOKUP)
            hs_lt_reg <= LW'(hs_rd_reg) < live_reg;
        if (m_load)
            m_res_reg <= m_load_res;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            hs_rd_reg <= handle_slot[in_hidx];
        if (hs_we)
            handle_slot[hs_waddr] <= hs_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (owner_re)
            owner_rd_reg <= slot_owner[owner_raddr];
        if (owner_we)
            slot_owner[owner_waddr] <= owner_wdata;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.status;
    assign m_tdata  = {4'b0,
                       m_res_reg.live_count,
                       m_res_reg.from_row,
                       m_res_reg.from_col,
                       m_res_reg.from_page,
                       m_res_reg.moved_handle,
                       m_res_reg.moved,
                       m_res_reg.page_released,
                       m_res_reg.new_page,
                       m_res_reg.slot_row,
                       m_res_reg.slot_col,
                       m_res_reg.page_index};

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import das_pkg::*;

    localparam int MAX_TILES   = 1024;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_CYCLES = 500;
    localparam int SETTLE      = 4;
    localparam int TAIL_WAIT   = 60;

    typedef enum bit [1:0] {ROW_ALLOC, ROW_FREE, ROW_SET_COLS, ROW_SET_ROWS} row_kind_t;

    typedef struct {
        row_kind_t kind;
        int        arg;
        bit        typed;
        result_t   want;
    } stim_row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [15:0]         s_tdata;   // [9:0] handle
    logic [0:0]          s_tuser;   // [0] command
    logic                m_tvalid;
    logic                m_tready;
    // [9:0] page_index, [15:10] slot_col, [21:16] slot_row, [22] new_page,
    // [23] page_released, [24] moved, [34:25] moved_handle, [44:35] from_page,
    // [50:45] from_col, [56:51] from_row, [67:57] live_count
    logic [71:0]         m_tdata;
    logic [1:0]          m_tuser;   // [1:0] status
    logic                cfg_we;
    logic [0:0]          cfg_index;
    logic [DIM_W-1:0]    cfg_data;

    // allocator shadow
    logic [DIM_W-1:0]    cols_reg;
    logic [DIM_W-1:0]    rows_reg;
    int                  tiles_live;
    logic [HANDLE_W-1:0] owner_of_slot [MAX_TILES];
    int                  slot_of_handle [MAX_TILES];
    bit                  handle_live [MAX_TILES];
    bit                  handle_seen [MAX_TILES];

    result_t             awaited_results [$];
    stim_row_t           directed_rows [$];
    int                  mismatches = 0;
    int                  results_taken = 0;
    int                  cycle_count = 0;
    bit                  idle_enabled = 1'b1;

    dense_atlas_slot_allocator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("dense_atlas_slot_allocator verification failed");
            $finish;
        end
    end

    function automatic int effective_dim(input logic [DIM_W-1:0] v);
        if (v == 0)
            return 1;
        return (v > 64) ? 64 : int'(v);
    endfunction

    function automatic int page_capacity();
        return effective_dim(cols_reg) * effective_dim(rows_reg);
    endfunction

    function automatic void slot_position(input int s, output logic [PAGE_W-1:0] pg,
                                          output logic [POS_W-1:0] c,
                                          output logic [POS_W-1:0] r);
        int width;
        int on_page;
        width = effective_dim(cols_reg);
        on_page = s % page_capacity();
        pg = PAGE_W'(s / page_capacity());
        c = POS_W'(on_page % width);
        r = POS_W'(on_page / width);
    endfunction

    function automatic result_t make_result(input int st, input int pg, input int c, input int r,
                                            input int np, input int rel, input int mv,
                                            input int mh, input int fp, input int fc,
                                            input int fr, input int live);
        result_t res;
        res.status        = STATUS_W'(st);
        res.page_index    = PAGE_W'(pg);
        res.slot_col      = POS_W'(c);
        res.slot_row      = POS_W'(r);
        res.new_page      = np[0];
        res.page_released = rel[0];
        res.moved         = mv[0];
        res.moved_handle  = HANDLE_W'(mh);
        res.from_page     = PAGE_W'(fp);
        res.from_col      = POS_W'(fc);
        res.from_row      = POS_W'(fr);
        res.live_count    = LIVE_W'(live);
        return res;
    endfunction

    // Swap-remove placement: free pulls the tile in the last slot into the hole.
    function automatic result_t predict_placement(input logic cmd, input logic [HANDLE_W-1:0] h);
        result_t res;
        int hole;
        int last;
        logic [HANDLE_W-1:0] mover;
        res = '0;
        if (cmd == CMD_ALLOC)
        begin
            if (tiles_live >= MAX_TILES)
                res.status = STATUS_FULL;
            else if (handle_live[h])
                res.status = STATUS_BAD;
            else
            begin
                slot_position(tiles_live, res.page_index, res.slot_col, res.slot_row);
                res.new_page = (tiles_live % page_capacity() == 0);
                owner_of_slot[tiles_live] = h;
                slot_of_handle[h] = tiles_live;
                handle_live[h] = 1'b1;
                handle_seen[h] = 1'b1;
                tiles_live++;
            end
        end
        else
        begin
            if (tiles_live == 0 || !handle_live[h])
                res.status = STATUS_BAD;
            else
            begin
                hole = slot_of_handle[h];
                last = tiles_live - 1;
                slot_position(hole, res.page_index, res.slot_col, res.slot_row);
                if (hole != last)
                begin
                    mover = owner_of_slot[last];
                    res.moved = 1'b1;
                    res.moved_handle = mover;
                    slot_position(last, res.from_page, res.from_col, res.from_row);
                    owner_of_slot[hole] = mover;
                    slot_of_handle[mover] = hole;
                end
                handle_live[h] = 1'b0;
                tiles_live = last;
                res.page_released = (last % page_capacity() == 0);
            end
        end
        res.live_count = LIVE_W'(tiles_live);
        return res;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        if (!idle_enabled)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic offer_item(input logic cmd, input logic [HANDLE_W-1:0] h, input bit typed,
                              input result_t want);
        result_t predicted;
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= 16'(h);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = predict_placement(cmd, h);
        awaited_results.push_back(typed ? want : predicted);
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_for_idle();
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_register(input logic idx, input logic [DIM_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_COLS)
            cols_reg = value;
        else
            rows_reg = value;
        @(posedge clk);
    endtask

    task automatic start_phase(input logic [DIM_W-1:0] c, input logic [DIM_W-1:0] r,
                               input bit idle_on);
        wait_for_idle();
        set_register(CFG_COLS, c);
        set_register(CFG_ROWS, r);
        idle_enabled = idle_on;
    endtask

    // Mostly well-formed allocate/free traffic; ~8% bad requests.
    task automatic random_item(input int alloc_pct);
        logic cmd;
        logic [HANDLE_W-1:0] h;
        bit found;
        int start;
        int k;
        found = 1'b0;
        h = '0;
        if ($urandom_range(0, 99) < 8)
        begin
            if (tiles_live == 0 || $urandom_range(0, 1) == 1)
            begin
                // free of a handle that was bound once and is gone now
                cmd = CMD_FREE;
                start = $urandom_range(0, MAX_TILES - 1);
                for (k = 0; k < MAX_TILES && !found; k++)
                begin
                    h = HANDLE_W'(start + k);
                    found = handle_seen[h] && !handle_live[h];
                end
            end
            if (!found)
            begin
                cmd = CMD_ALLOC;
                if (tiles_live > 0)
                    h = owner_of_slot[$urandom_range(0, tiles_live - 1)];
                else
                    h = HANDLE_W'($urandom);
            end
        end
        else if (tiles_live == 0 || $urandom_range(0, 99) < alloc_pct)
        begin
            cmd = CMD_ALLOC;
            if (tiles_live == MAX_TILES)
                h = HANDLE_W'($urandom);
            else
            begin
                start = $urandom_range(0, MAX_TILES - 1);
                for (k = 0; k < MAX_TILES && !found; k++)
                begin
                    h = HANDLE_W'(start + k);
                    found = !handle_live[h];
                end
            end
        end
        else
        begin
            cmd = CMD_FREE;
            if ($urandom_range(0, 6) == 0)
                h = owner_of_slot[tiles_live - 1];
            else
                h = owner_of_slot[$urandom_range(0, tiles_live - 1)];
        end
        offer_item(cmd, h, 1'b0, '0);
    endtask

    initial
    begin : result_sink
        int wait_left;
        result_t got;
        result_t want;
        wait_left = 0;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got.status        = m_tuser;
                got.page_index    = m_tdata[9:0];
                got.slot_col      = m_tdata[15:10];
                got.slot_row      = m_tdata[21:16];
                got.new_page      = m_tdata[22];
                got.page_released = m_tdata[23];
                got.moved         = m_tdata[24];
                got.moved_handle  = m_tdata[34:25];
                got.from_page     = m_tdata[44:35];
                got.from_col      = m_tdata[50:45];
                got.from_row      = m_tdata[56:51];
                got.live_count    = m_tdata[67:57];
                results_taken++;
                if (awaited_results.size() == 0)
                begin
                    $error("result arrived with no item outstanding");
                    mismatches++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    compare_field("status", want.status, got.status);
                    compare_field("page_index", want.page_index, got.page_index);
                    compare_field("slot_col", want.slot_col, got.slot_col);
                    compare_field("slot_row", want.slot_row, got.slot_row);
                    compare_field("new_page", want.new_page, got.new_page);
                    compare_field("page_released", want.page_released, got.page_released);
                    compare_field("moved", want.moved, got.moved);
                    compare_field("moved_handle", want.moved_handle, got.moved_handle);
                    compare_field("from_page", want.from_page, got.from_page);
                    compare_field("from_col", want.from_col, got.from_col);
                    compare_field("from_row", want.from_row, got.from_row);
                    compare_field("live_count", want.live_count, got.live_count);
                end
                // one long hold-off so the block backs up into its input
                wait_left = (results_taken == HOLD_AT) ? HOLD_CYCLES : pick_gap();
            end
            else if (wait_left > 0)
                wait_left--;
            m_tready <= (wait_left == 0);
        end
    end

    initial
    begin : stimulus
        stim_row_t r;
        int i;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        cols_reg  = 7'd8;
        rows_reg  = 7'd8;
        tiles_live = 0;
        for (i = 0; i < MAX_TILES; i++)
        begin
            owner_of_slot[i]  = '0;
            slot_of_handle[i] = 0;
            handle_live[i]    = 1'b0;
            handle_seen[i]    = 1'b0;
        end

        // reset shape 8x8
        directed_rows.push_back('{ROW_ALLOC, 0, 1, make_result(0, 0,0,0, 1,0,0, 0, 0,0,0, 1)});
        directed_rows.push_back('{ROW_FREE, 0, 1, make_result(0, 0,0,0, 0,1,0, 0, 0,0,0, 0)});
        // free on an empty store
        directed_rows.push_back('{ROW_FREE, 0, 1, make_result(2, 0,0,0, 0,0,0, 0, 0,0,0, 0)});
        directed_rows.push_back('{ROW_ALLOC, 1023, 1, make_result(0, 0,0,0, 1,0,0, 0, 0,0,0, 1)});
        // handle already bound
        directed_rows.push_back('{ROW_ALLOC, 1023, 1, make_result(2, 0,0,0, 0,0,0, 0, 0,0,0, 1)});
        directed_rows.push_back('{ROW_ALLOC, 5, 1, make_result(0, 0,1,0, 0,0,0, 0, 0,0,0, 2)});
        directed_rows.push_back('{ROW_ALLOC, 7, 1, make_result(0, 0,2,0, 0,0,0, 0, 0,0,0, 3)});
        // handle not live
        directed_rows.push_back('{ROW_FREE, 0, 1, make_result(2, 0,0,0, 0,0,0, 0, 0,0,0, 3)});
        directed_rows.push_back('{ROW_FREE, 1023, 1, make_result(0, 0,0,0, 0,0,1, 7, 0,2,0, 2)});
        directed_rows.push_back('{ROW_FREE, 7, 1, make_result(0, 0,0,0, 0,0,1, 5, 0,1,0, 1)});
        // freeing the tail slot: nothing moves
        directed_rows.push_back('{ROW_FREE, 5, 1, make_result(0, 0,0,0, 0,1,0, 0, 0,0,0, 0)});
        // 2x2 pages: cross a page boundary both ways
        directed_rows.push_back('{ROW_SET_COLS, 2, 0, '0});
        directed_rows.push_back('{ROW_SET_ROWS, 2, 0, '0});
        directed_rows.push_back('{ROW_ALLOC, 10, 1, make_result(0, 0,0,0, 1,0,0, 0, 0,0,0, 1)});
        directed_rows.push_back('{ROW_ALLOC, 11, 0, '0});
        directed_rows.push_back('{ROW_ALLOC, 12, 0, '0});
        directed_rows.push_back('{ROW_ALLOC, 13, 0, '0});
        directed_rows.push_back('{ROW_ALLOC, 14, 1, make_result(0, 1,0,0, 1,0,0, 0, 0,0,0, 5)});
        directed_rows.push_back('{ROW_FREE, 10, 1, make_result(0, 0,0,0, 0,1,1, 14, 1,0,0, 4)});
        directed_rows.push_back('{ROW_FREE, 13, 0, '0});
        // out-of-range shape clamps to 1x64, applied to live tiles at once
        directed_rows.push_back('{ROW_SET_COLS, 0, 0, '0});
        directed_rows.push_back('{ROW_SET_ROWS, 127, 0, '0});
        directed_rows.push_back('{ROW_FREE, 14, 0, '0});

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            r = directed_rows[i];
            case (r.kind)
                ROW_SET_COLS:
                begin
                    wait_for_idle();
                    set_register(CFG_COLS, DIM_W'(r.arg));
                end
                ROW_SET_ROWS:
                begin
                    wait_for_idle();
                    set_register(CFG_ROWS, DIM_W'(r.arg));
                end
                ROW_ALLOC:
                    offer_item(CMD_ALLOC, HANDLE_W'(r.arg), r.typed, r.want);
                default:
                    offer_item(CMD_FREE, HANDLE_W'(r.arg), r.typed, r.want);
            endcase
        end

        // one tile per page, no idling
        start_phase(7'd1, 7'd1, 1'b0);
        repeat (120) random_item(60);

        start_phase(7'd3, 7'd5, 1'b1);
        while (tiles_live < 500)
            random_item(92);

        // fill to capacity, then knock on a full store
        start_phase(7'd127, 7'd127, 1'b1);
        while (tiles_live < MAX_TILES)
            random_item(92);
        repeat (20) random_item(92);

        start_phase(7'd64, 7'd1, 1'b1);
        repeat (120) random_item(30);

        start_phase(DIM_W'($urandom_range(0, 127)), DIM_W'($urandom_range(0, 127)), 1'b1);
        repeat (130) random_item(35);

        wait_for_idle();
        repeat (TAIL_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("dense_atlas_slot_allocator verification clean");
        else
            $display("dense_atlas_slot_allocator verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/das_pkg.sv
rtl/das_divider.sv
rtl/das_place.sv
rtl/dense_atlas_slot_allocator.sv
tb/tb_top.sv
